/* hdl/qts_pkg.sv */
package qts_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

/* hdl/queue_from_two_stacks_unit.sv */
// FIFO of signed words built from an inbound and an outbound stack in two RAMs.
// Enqueue and empty dequeue pass through the result stage to the output register; a
// dequeue from a loaded outbound stack first reads the RAM (S_POP); a dequeue that moves n
// inbound words (S_MOVE, one word a cycle) returns the oldest. New requests wait for idle.
// The transfer rate is set by the single read port of the inbound RAM.
// Reset (rst, synchronous): counts cleared, capacity 256; RAM contents are not cleared.
module queue_from_two_stacks_unit #(
  parameter int MAX_DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_write_en,
  input  logic [qts_pkg::CAP_W-1:0]  cfg_write_data,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       opcode,
  input  logic signed [31:0]         value,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         data,
  output logic [1:0]                 status
);

  localparam int AW   = $clog2(MAX_DEPTH);
  localparam int CW   = $clog2(MAX_DEPTH + 1);
  localparam int CMPW = (CW > qts_pkg::CAP_W) ? CW : qts_pkg::CAP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_MOVE
  } state_t;

  state_t state;

  logic [qts_pkg::CAP_W-1:0]  stack_capacity;
  logic [CW-1:0]              inbound_count;
  logic [CW-1:0]              outbound_count;

  // transfer sequencer: source address last read, destination slot, last slot
  logic [AW-1:0]              mv_src;
  logic [AW-1:0]              mv_dst;
  logic [AW-1:0]              mv_last;

  // result stage ahead of the output register
  logic                       res_pending;
  logic [qts_pkg::DATA_W-1:0] res_data;
  qts_pkg::status_t           res_status;

  logic [qts_pkg::DATA_W-1:0] out_data;
  qts_pkg::status_t           out_status;

  // RAM ports
  logic                       ib_we;
  logic [AW-1:0]              ib_raddr;
  logic [qts_pkg::DATA_W-1:0] ib_rdata;
  logic                       ob_we;
  logic [AW-1:0]              ob_raddr;
  logic [qts_pkg::DATA_W-1:0] ob_rdata;

  logic                       accept;
  logic                       inbound_full;
  logic                       res_load;
  logic                       mv_done;
  logic [CW-1:0]              ib_top;
  logic [CW-1:0]              ob_top;

  assign in_stall = (state != S_IDLE) || res_pending;
  assign accept   = in_valid && !in_stall;

  // full while the count sits at or above the capacity, or at the physical depth
  assign inbound_full = (CMPW'(inbound_count) >= CMPW'(stack_capacity)) ||
                        (inbound_count == CW'(MAX_DEPTH));

  assign ib_top  = inbound_count - 1'b1;
  assign ob_top  = outbound_count - 1'b1;
  assign mv_done = (mv_dst == mv_last);

  // hand the result word on when the output register is free or being taken
  assign res_load = res_pending && (!out_valid || !out_stall);

  always_comb begin
    ib_we    = accept && (opcode == qts_pkg::OP_ENQUEUE) && !inbound_full;
    ob_we    = (state == S_MOVE);
    ob_raddr = ob_top[AW-1:0];
    if (state == S_MOVE) begin
      ib_raddr = mv_src - 1'b1;
    end else begin
      ib_raddr = ib_top[AW-1:0];
    end
  end

  qts_ram #(.DEPTH(MAX_DEPTH)) u_inbound (
    .clk   (clk),
    .we    (ib_we),
    .waddr (inbound_count[AW-1:0]),
    .wdata (value),
    .raddr (ib_raddr),
    .rdata (ib_rdata)
  );

  // transfer writes outbound[i] = inbound[n-1-i]
  qts_ram #(.DEPTH(MAX_DEPTH)) u_outbound (
    .clk   (clk),
    .we    (ob_we),
    .waddr (mv_dst),
    .wdata (ib_rdata),
    .raddr (ob_raddr),
    .rdata (ob_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      stack_capacity <= qts_pkg::CAP_RESET;
      inbound_count  <= '0;
      outbound_count <= '0;
      res_pending    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        stack_capacity <= cfg_write_data;
      end

      // output register: drop the word once taken, refill from the result stage
      if (res_load) begin
        out_valid  <= 1'b1;
        out_data   <= res_data;
        out_status <= res_status;
        res_pending <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (opcode == qts_pkg::OP_ENQUEUE) begin
              res_pending <= 1'b1;
              res_data    <= '0;
              if (inbound_full) begin
                res_status <= qts_pkg::ST_FULL;
              end else begin
                res_status    <= qts_pkg::ST_OK;
                inbound_count <= inbound_count + 1'b1;
              end
            end else if (outbound_count != '0) begin
              // top of the outbound stack is being read
              outbound_count <= ob_top;
              state          <= S_POP;
            end else if (inbound_count != '0) begin
              // first inbound read (the newest word) issued now
              mv_src        <= ib_top[AW-1:0];
              mv_dst        <= '0;
              mv_last       <= ib_top[AW-1:0];
              inbound_count <= '0;
              state         <= S_MOVE;
            end else begin
              res_pending <= 1'b1;
              res_data    <= '0;
              res_status  <= qts_pkg::ST_EMPTY;
            end
          end
        end

        S_POP: begin
          res_pending <= 1'b1;
          res_data    <= ob_rdata;
          res_status  <= qts_pkg::ST_OK;
          state       <= S_IDLE;
        end

        S_MOVE: begin
          if (mv_done) begin
            // the oldest word lands in the top slot: return it straight away
            res_pending    <= 1'b1;
            res_data       <= ib_rdata;
            res_status     <= qts_pkg::ST_OK;
            outbound_count <= CW'(mv_last);
            state          <= S_IDLE;
          end else begin
            mv_src <= mv_src - 1'b1;
            mv_dst <= mv_dst + 1'b1;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign data   = out_data;
  assign status = out_status;

endmodule

/* hdl/qts_ram.sv */
module qts_ram #(
  parameter int DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  logic [qts_pkg::DATA_W-1:0]    wdata,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output logic [qts_pkg::DATA_W-1:0]    rdata
);

  logic [qts_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* test/qts_checker.sv */
`timescale 1ns / 1ps

module qts_checker #(
  parameter int MAX_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [qts_pkg::CAP_W-1:0]         cfg_write_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              opcode,
  input  logic signed [qts_pkg::DATA_W-1:0] value,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [qts_pkg::DATA_W-1:0] data,
  input  logic [1:0]                        status,
  output int                                mismatches,
  output int                                pending_words
);

  typedef struct packed {
    logic [qts_pkg::DATA_W-1:0] data;
    qts_pkg::status_t           status;
  } reply_t;

  // Mirror of the two stacks
  logic [qts_pkg::DATA_W-1:0] in_stack  [MAX_DEPTH];
  logic [qts_pkg::DATA_W-1:0] out_stack [MAX_DEPTH];
  int                in_depth;
  int                out_depth;
  int                capacity;

  reply_t            reply_q[$];
  reply_t            want;

  task automatic report_mismatch(input string what, input logic [qts_pkg::DATA_W-1:0] got,
                                 input logic [qts_pkg::DATA_W-1:0] exp_word);
    if (mismatches < 100)
      $display("[%0t] %s: got %h, want %h", $time, what, got, exp_word);
    mismatches++;
  endtask

  // Apply one request to the mirror and return the reply it earns.
  function automatic reply_t apply_request(input logic op,
                                           input logic [qts_pkg::DATA_W-1:0] word);
    reply_t r;
    int     lim;
    r.data   = '0;
    r.status = qts_pkg::ST_OK;
    lim = (capacity > MAX_DEPTH) ? MAX_DEPTH : capacity;
    if (op == qts_pkg::OP_ENQUEUE) begin
      if (in_depth >= lim) begin
        r.status = qts_pkg::ST_FULL;
      end else begin
        in_stack[in_depth] = word;
        in_depth++;
      end
    end else begin
      if (out_depth == 0) begin
        if (in_depth == 0) begin
          r.status = qts_pkg::ST_EMPTY;
        end else begin
          // Move everything across, oldest ends on top
          for (int i = 0; i < in_depth; i++)
            out_stack[i] = in_stack[in_depth - 1 - i];
          out_depth = in_depth;
          in_depth  = 0;
        end
      end
      if (r.status == qts_pkg::ST_OK) begin
        out_depth--;
        r.data = out_stack[out_depth];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_depth  = 0;
      out_depth = 0;
      capacity  = int'(qts_pkg::CAP_RESET);
      reply_q.delete();
    end else begin
      if (cfg_write_en)
        capacity = int'(cfg_write_data);
      // Results never share an edge with their own request, so check first.
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          report_mismatch("word with nothing pending", data, '0);
        end else begin
          want = reply_q.pop_front();
          if (data !== want.data)
            report_mismatch("data", data, want.data);
          if (status !== want.status)
            report_mismatch("status", qts_pkg::DATA_W'(status),
                            qts_pkg::DATA_W'(want.status));
        end
      end
      if (in_valid && !in_stall)
        reply_q.push_back(apply_request(opcode, value));
    end
    pending_words <= reply_q.size();
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_DEPTH  = 256;
  // Longest legal quiet stretch is the receiver hold-off or a full
  // transfer; leave plenty of margin on top of both.
  localparam int IDLE_LIMIT = 3000;

  logic                              clk            = 1'b0;
  logic                              rst            = 1'b1;
  logic                              cfg_write_en   = 1'b0;
  logic [qts_pkg::CAP_W-1:0]         cfg_write_data = '0;
  logic                              in_valid       = 1'b0;
  logic                              in_stall;
  logic                              opcode         = 1'b0;
  logic signed [qts_pkg::DATA_W-1:0] value          = '0;
  logic                              out_valid;
  logic                              out_stall      = 1'b0;
  logic signed [qts_pkg::DATA_W-1:0] data;
  logic [1:0]                        status;

  int mismatches;
  int pending_words;
  int idle_cycles = 0;

  // Knobs set by the stimulus; the rx_ ones steer the receiver
  bit tx_calm     = 1'b0;
  bit rx_calm     = 1'b0;
  int rx_hold_req = 0;

  int cap_plan [11] = '{3, 1, 256, 8, 0, 511, 2, 40, 5, 300, 17};

  always #5 clk = ~clk;

  queue_from_two_stacks_unit #(
    .MAX_DEPTH(MAX_DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .data          (data),
    .status        (status)
  );

  qts_checker #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .data          (data),
    .status        (status),
    .mismatches    (mismatches),
    .pending_words (pending_words)
  );

  // Watchdog: end the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver: stall at random before each word, or not at all in
  // calm stretches. On request, hold off for a long stretch so the unit backs up.
  initial begin : receiver
    int gap;
    int holds_done;
    holds_done = 0;
    wait (!rst);
    forever begin
      gap = rx_calm ? 0 : $urandom_range(0, 6);
      if (holds_done != rx_hold_req) begin
        gap        = 300;
        holds_done = rx_hold_req;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Mostly random words, with the sign and all-ones/all-zeros corners mixed in.
  function automatic logic [qts_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Offer one word after a random gap; return at the edge that accepts it.
  task automatic send_word(input qts_pkg::opcode_t op, input logic [qts_pkg::DATA_W-1:0] v);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and hold until every predicted word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  // Only called with the unit idle.
  task automatic write_capacity(input int cap);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= cap[qts_pkg::CAP_W-1:0];
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  // Random runs of enqueues and dequeues sized to the capacity, so the queue
  // swings between full and empty. Big capacities start with a full fill.
  task automatic run_traffic(input int budget, input int cap);
    int eff;
    int left;
    int len;
    int run_max;
    bit enq;
    eff     = (cap > MAX_DEPTH) ? MAX_DEPTH : cap;
    left    = budget;
    run_max = (eff + 2 > 24) ? 24 : eff + 2;
    if (eff > 24) begin
      repeat (eff + 3) send_word(qts_pkg::OP_ENQUEUE, pick_value());
      left -= eff + 3;
    end
    while (left > 0) begin
      enq = $urandom_range(0, 1);
      if (enq && $urandom_range(0, 7) == 0)
        len = eff + 3;
      else
        len = $urandom_range(1, run_max);
      repeat (len) send_word(enq ? qts_pkg::OP_ENQUEUE : qts_pkg::OP_DEQUEUE, pick_value());
      left -= len;
    end
  endtask

  initial begin : stimulus
    int cap;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty dequeue, corner words, transfer with reversal,
    // pops from a loaded outbound stack.
    write_capacity(256);
    send_word(qts_pkg::OP_DEQUEUE, 32'h0000_0000);
    send_word(qts_pkg::OP_ENQUEUE, 32'h8000_0000);
    send_word(qts_pkg::OP_ENQUEUE, 32'h7FFF_FFFF);
    send_word(qts_pkg::OP_ENQUEUE, 32'hFFFF_FFFF);
    send_word(qts_pkg::OP_ENQUEUE, 32'h0000_0000);
    send_word(qts_pkg::OP_DEQUEUE, 32'hFFFF_FFFF);
    send_word(qts_pkg::OP_ENQUEUE, 32'hA5A5_A5A5);
    send_word(qts_pkg::OP_DEQUEUE, 32'h0000_0000);
    send_word(qts_pkg::OP_DEQUEUE, 32'h0000_0000);
    drain_results();

    // Lower the capacity with words held: refuse once inbound reaches it,
    // even though the outbound stack has room.
    write_capacity(2);
    send_word(qts_pkg::OP_ENQUEUE, 32'h5A5A_5A5A);
    send_word(qts_pkg::OP_ENQUEUE, 32'h0000_0001);
    send_word(qts_pkg::OP_ENQUEUE, 32'h1234_5678);
    drain_results();

    // Capacity zero: every enqueue refused, held words still come out.
    write_capacity(0);
    send_word(qts_pkg::OP_DEQUEUE, 32'h0000_0000);
    send_word(qts_pkg::OP_DEQUEUE, 32'h0000_0000);
    send_word(qts_pkg::OP_DEQUEUE, 32'h0000_0000);
    send_word(qts_pkg::OP_ENQUEUE, 32'h0000_0007);
    send_word(qts_pkg::OP_DEQUEUE, 32'h0000_0000);
    drain_results();

    // Capacity above the depth saturates.
    write_capacity(511);
    send_word(qts_pkg::OP_ENQUEUE, 32'h1234_5678);
    send_word(qts_pkg::OP_DEQUEUE, 32'h0000_0000);
    send_word(qts_pkg::OP_DEQUEUE, 32'h0000_0000);
    drain_results();

    write_capacity(1);
    send_word(qts_pkg::OP_ENQUEUE, 32'h0000_0001);
    send_word(qts_pkg::OP_ENQUEUE, 32'h0000_0002);
    send_word(qts_pkg::OP_DEQUEUE, 32'h0000_0000);
    send_word(qts_pkg::OP_DEQUEUE, 32'h0000_0000);
    drain_results();

    // Random phases; the queue is not emptied between them, so each new
    // capacity often lands below what is already held.
    for (int p = 0; p < 12; p++) begin
      cap     = (p == 11) ? $urandom_range(0, 511) : cap_plan[p];
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      write_capacity(cap);
      if (p == 2 || p == 7)
        rx_hold_req++;
      if (p == 4) begin
        // Pause the sender mid-phase until everything is back.
        run_traffic(50, cap);
        drain_results();
        run_traffic(50, cap);
      end else begin
        run_traffic(100, cap);
      end
      drain_results();
    end

    // Let any straggler show up before the verdict.
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
